FILE: rtl/xhwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package xhwm_pkg;

    localparam int EXPONENT_TENTHS = 20;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [63:0] FULL_Q78 = 64'd32512;
    localparam logic [32:0] LIMIT_Q22 = 33'(64'd127 << 22);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int DIV_STEPS = 7;

    localparam logic [1:0] REG_DEADBAND = 2'd0;
    localparam logic [1:0] REG_PARK = 2'd1;

    typedef logic [127:0][15:0] expo_rom_t;
    typedef logic [900:0][14:0] sine_rom_t;

    typedef struct packed {
        logic signed [15:0] fwd;
        logic signed [15:0] str;
        logic signed [15:0] rot;
        logic               rot_en;
        logic               park;
        logic [9:0]         sin_idx;
        logic               sin_neg;
        logic [9:0]         cos_idx;
        logic               cos_neg;
    } item_t;

    typedef struct packed {
        logic              park;
        logic              big;
        logic [32:0]       dmax;
        logic [3:0]        neg;
        logic [3:0][6:0]   low;
        logic [3:0][39:0]  rem;
        logic [3:0][6:0]   quo;
    } div_stage_t;

    function automatic logic [63:0] mul_q30(logic [63:0] a, logic [63:0] b);
        return (a * b) >> 30;
    endfunction

    function automatic logic [63:0] pow_q30(logic [63:0] x, int n);
        logic [63:0] r;
        r = ONE_Q30;
        for (int i = 0; i < n; i++)
        begin
            r = mul_q30(r, x);
        end
        return r;
    endfunction

    function automatic expo_rom_t build_expo();
        expo_rom_t rom;
        logic [63:0] x, target, lo, hi, mid, f;
        for (int m = 0; m < 128; m++)
        begin
            x = ((64'(m) << 30) + 64'd63) / 64'd127;
            target = pow_q30(x, EXPONENT_TENTHS % 10);
            lo = 64'd0;
            hi = ONE_Q30;
            while (lo < hi)
            begin
                mid = lo + (hi - lo + 64'd1) / 64'd2;
                if (pow_q30(mid, 10) <= target)
                    lo = mid;
                else
                    hi = mid - 64'd1;
            end
            f = mul_q30(pow_q30(x, EXPONENT_TENTHS / 10), lo);
            rom[m] = 16'((f * FULL_Q78 + (ONE_Q30 >> 1)) >> 30);
        end
        return rom;
    endfunction

    function automatic sine_rom_t build_sine();
        sine_rom_t rom;
        logic [63:0] th, th2, t, e;
        logic signed [63:0] sum;
        for (int k = 0; k <= 900; k++)
        begin
            th = 64'(k) * PI_Q30 / 64'd1800;
            th2 = (th * th) >> 30;
            t = th;
            sum = $signed(t);
            for (int i = 0; i < 12; i++)
            begin
                t = ((t * th2) >> 30) / 64'((2 * i + 2) * (2 * i + 3));
                if (i % 2 == 0)
                    sum = sum - $signed(t);
                else
                    sum = sum + $signed(t);
            end
            if (sum < 0)
                sum = 0;
            e = ($unsigned(sum) + (64'd1 << 15)) >> 16;
            if (e > 64'd16384)
                e = 64'd16384;
            rom[k] = 15'(e);
        end
        return rom;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/xhwm_front.sv
`timescale 1ns / 1ps
`default_nettype none
module xhwm_front
    import xhwm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [6:0]        cfg_data,
    input  wire logic signed [7:0] forward_cmd,
    input  wire logic signed [7:0] strafe_cmd,
    input  wire logic signed [7:0] rotate_cmd,
    input  wire logic              frame_rot,
    input  wire logic              heading_valid,
    input  wire logic [11:0]       heading_tenths,
    output item_t                  item
);

    localparam expo_rom_t EXPO_ROM = build_expo();

    logic [6:0] deadband_reg;
    logic       park_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg <= 7'd5;
            park_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_DEADBAND)
                deadband_reg <= cfg_data;
            else if (cfg_index == REG_PARK)
                park_reg <= cfg_data[0];
        end
    end

    function automatic logic signed [15:0] shape(logic signed [7:0] raw, logic [6:0] db);
        logic [6:0] mag;
        logic signed [15:0] v;
        // -128 folds onto -127
        mag = raw[7] ? ((raw == -8'sd128) ? 7'd127 : 7'(-raw)) : raw[6:0];
        v = $signed(EXPO_ROM[mag]);
        if (mag < db)
            return 16'sd0;
        return raw[7] ? -v : v;
    endfunction

    // quarter-wave index and sign for an angle below 3600
    function automatic logic [10:0] quarter(logic [11:0] h);
        logic [1:0]  q;
        logic [11:0] r;
        logic [9:0]  idx;
        if (h < 12'd900)
        begin
            q = 2'd0;
            r = h;
        end
        else if (h < 12'd1800)
        begin
            q = 2'd1;
            r = h - 12'd900;
        end
        else if (h < 12'd2700)
        begin
            q = 2'd2;
            r = h - 12'd1800;
        end
        else
        begin
            q = 2'd3;
            r = h - 12'd2700;
        end
        idx = q[0] ? 10'(12'd900 - r) : r[9:0];
        return {q[1], idx};
    endfunction

    logic [11:0] h;
    logic [12:0] hc_sum;
    logic [11:0] hc;
    logic [10:0] sq, cq;

    always_comb
    begin
        h = (heading_tenths >= 12'd3600) ? heading_tenths - 12'd3600 : heading_tenths;
        hc_sum = {1'b0, h} + 13'd900;
        hc = (hc_sum >= 13'd3600) ? 12'(hc_sum - 13'd3600) : hc_sum[11:0];
        sq = quarter(h);
        cq = quarter(hc);
        item.fwd = shape(forward_cmd, deadband_reg);
        item.str = shape(strafe_cmd, deadband_reg);
        item.rot = shape(rotate_cmd, deadband_reg);
        item.rot_en = frame_rot & heading_valid;
        item.park = park_reg;
        item.sin_idx = sq[9:0];
        item.sin_neg = sq[10];
        item.cos_idx = cq[9:0];
        item.cos_neg = cq[10];
    end

endmodule
`default_nettype wire

FILE: rtl/xhwm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module xhwm_queue
    import xhwm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output logic       empty,
    output item_t      head
);

    item_t mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QPTR_W:0]   count_reg;

    assign full = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule
`default_nettype wire

FILE: rtl/xhwm_back.sv
`timescale 1ns / 1ps
`default_nettype none
module xhwm_back
    import xhwm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  empty,
    input  wire item_t head,
    output logic       pop,
    output logic       out_valid,
    input  wire logic  out_ready,
    output logic [31:0] out_data
);

    localparam sine_rom_t SINE_ROM = build_sine();

    logic adv;

    // stage 1: table read
    logic        v1_reg;
    item_t       it1_reg;
    logic [14:0] smag_reg, cmag_reg;
    // stage 2: products
    logic               v2_reg, park2_reg;
    logic signed [31:0] p_sc_reg, p_fs_reg, p_fc_reg, p_ss_reg, r22_reg;
    // stage 3: wheel sums
    logic               v3_reg, park3_reg;
    logic signed [33:0] w_reg [4];
    // stage 4: magnitudes
    logic               v4_reg, park4_reg;
    logic [3:0]         neg4_reg;
    logic [3:0][32:0]   mag4_reg;
    // divide pipeline
    logic [DIV_STEPS:0] dv_reg;
    div_stage_t div_reg [DIV_STEPS+1];

    logic        out_valid_reg;
    logic [31:0] out_data_reg;

    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && !empty;
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    logic signed [15:0] s_val, c_val;
    logic signed [33:0] f22, s22, r22;
    logic [32:0] m01, m23, mmax;

    always_comb
    begin
        s_val = $signed({1'b0, smag_reg});
        c_val = $signed({1'b0, cmag_reg});
        if (it1_reg.sin_neg)
            s_val = -s_val;
        if (it1_reg.cos_neg)
            c_val = -c_val;
        if (!it1_reg.rot_en)
        begin
            s_val = 16'sd0;
            c_val = 16'sd16384;
        end
        s22 = 34'(p_sc_reg) - 34'(p_fs_reg);
        f22 = 34'(p_fc_reg) + 34'(p_ss_reg);
        r22 = 34'(r22_reg);
        m01 = (mag4_reg[0] > mag4_reg[1]) ? mag4_reg[0] : mag4_reg[1];
        m23 = (mag4_reg[2] > mag4_reg[3]) ? mag4_reg[2] : mag4_reg[3];
        mmax = (m01 > m23) ? m01 : m23;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            dv_reg <= '0;
        end
        else if (adv)
        begin
            v1_reg <= pop;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            dv_reg <= {dv_reg[DIV_STEPS-1:0], v4_reg};
            out_valid_reg <= dv_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it1_reg <= head;
            smag_reg <= SINE_ROM[head.sin_idx];
            cmag_reg <= SINE_ROM[head.cos_idx];

            park2_reg <= it1_reg.park;
            p_sc_reg <= it1_reg.str * c_val;
            p_fs_reg <= it1_reg.fwd * s_val;
            p_fc_reg <= it1_reg.fwd * c_val;
            p_ss_reg <= it1_reg.str * s_val;
            r22_reg <= 32'(it1_reg.rot) <<< 14;

            park3_reg <= park2_reg;
            w_reg[0] <= f22 + s22 + r22;
            w_reg[1] <= f22 - s22 - r22;
            w_reg[2] <= f22 - s22 + r22;
            w_reg[3] <= f22 + s22 - r22;

            park4_reg <= park3_reg;
            for (int i = 0; i < 4; i++)
            begin
                neg4_reg[i] <= w_reg[i][33];
                mag4_reg[i] <= w_reg[i][33] ? 33'(-w_reg[i]) : 33'(w_reg[i]);
            end

            div_reg[0].park <= park4_reg;
            div_reg[0].big <= mmax > LIMIT_Q22;
            div_reg[0].dmax <= mmax;
            div_reg[0].neg <= neg4_reg;
            for (int i = 0; i < 4; i++)
            begin
                div_reg[0].low[i] <= mag4_reg[i][28:22];
                div_reg[0].rem[i] <= 40'(mag4_reg[i]) * 40'd127;
                div_reg[0].quo[i] <= 7'd0;
            end

            // one quotient bit per stage, msb first
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                div_reg[k].park <= div_reg[k-1].park;
                div_reg[k].big <= div_reg[k-1].big;
                div_reg[k].dmax <= div_reg[k-1].dmax;
                div_reg[k].neg <= div_reg[k-1].neg;
                div_reg[k].low <= div_reg[k-1].low;
                for (int i = 0; i < 4; i++)
                begin
                    if (div_reg[k-1].rem[i] >= (40'(div_reg[k-1].dmax) << (DIV_STEPS - k)))
                    begin
                        div_reg[k].rem[i] <= div_reg[k-1].rem[i]
                            - (40'(div_reg[k-1].dmax) << (DIV_STEPS - k));
                        div_reg[k].quo[i] <= div_reg[k-1].quo[i] | (7'd1 << (DIV_STEPS - k));
                    end
                    else
                    begin
                        div_reg[k].rem[i] <= div_reg[k-1].rem[i];
                        div_reg[k].quo[i] <= div_reg[k-1].quo[i];
                    end
                end
            end

            for (int i = 0; i < 4; i++)
            begin
                logic [7:0] q;
                q = {1'b0, div_reg[DIV_STEPS].big ? div_reg[DIV_STEPS].quo[i]
                                                  : div_reg[DIV_STEPS].low[i]};
                if (div_reg[DIV_STEPS].park)
                    out_data_reg[i*8 +: 8] <= 8'd0;
                else
                    out_data_reg[i*8 +: 8] <= div_reg[DIV_STEPS].neg[i] ? -q : q;
            end
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_data_reg))
        else $error("result dropped while stalled");
    a_pop_adv: assert property (@(posedge clk) disable iff (!rst_n) pop |-> adv)
        else $error("pop while back end stalled");
    a_park_zero: assert property (@(posedge clk) disable iff (!rst_n)
        adv && dv_reg[DIV_STEPS] && div_reg[DIV_STEPS].park |=> out_data_reg == 32'd0)
        else $error("park result not zero");

endmodule
`default_nettype wire

FILE: rtl/xdrive_holonomic_wheel_mixer.sv
`timescale 1ns / 1ps
`default_nettype none
// channel    dir  data
// s_axis     in   tdata[39:0]: forward_cmd, strafe_cmd, rotate_cmd, frame_rot,
//                 heading_valid, heading_tenths, pad
// m_axis     out  tdata[31:0]: front_left, front_right, back_left, back_right
// cfg        in   cfg_index[1:0], cfg_data[6:0]: 0 deadband_level, 1 park_on
//
// one beat per cycle sustained while no output beat waits untaken; each beat passes in order
// through table read, products, sums, magnitudes, max, seven divide steps and output
// a four-entry queue parts shaping from the back pipeline, which stalls as a whole
// only while the output register holds an untaken beat
// reset clears control state and sets deadband 5, park off; no clearing pass
module xdrive_holonomic_wheel_mixer
    import xhwm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // forward, strafe, rotate, fc, hv, heading
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // front_left, front_right, back_left, back_right
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [6:0]  cfg_data
);

    item_t item, head;
    logic  full, empty, pop, push;

    assign s_axis_tready = !full;
    assign push = s_axis_tvalid && !full;

    xhwm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .forward_cmd    ($signed(s_axis_tdata[7:0])),
        .strafe_cmd     ($signed(s_axis_tdata[15:8])),
        .rotate_cmd     ($signed(s_axis_tdata[23:16])),
        .frame_rot      (s_axis_tdata[24]),
        .heading_valid  (s_axis_tdata[25]),
        .heading_tenths (s_axis_tdata[37:26]),
        .item           (item)
    );

    xhwm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (item),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    xhwm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
`default_nettype wire
